// ===== design/hbp_pkg.sv =====
// shared types, constants and helpers for the huffman encoder bit packer
// no dependencies; imported by every module of the block
package hbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYM_W        = 8;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int OP_W         = 2;
    localparam int BYTE_W       = 8;
    localparam int PEND_W       = BYTE_W - 1;
    localparam int ACC_W        = PEND_W + ((MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W);
    localparam int TOT_W        = $clog2(ACC_W + 1);
    localparam int TDATA_W      = ((SYM_W + CODE_W + LEN_W + 7) / 8) * 8;
    localparam int TABLE_DEPTH  = 1 << SYM_W;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_LVL_W      = $clog2(Q_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    // one job for the packer: append a code, or flush the leftover bits
    typedef struct packed {
        logic              flush;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } hbp_cmd_t;

    function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] n);
        logic [CODE_W-1:0] m;
        for (int i = 0; i < CODE_W; i++)
        begin
            m[i] = (LEN_W'(i) < n);
        end
        return m;
    endfunction

    function automatic logic [PEND_W-1:0] pend_mask(input logic [2:0] n);
        logic [PEND_W-1:0] m;
        for (int i = 0; i < PEND_W; i++)
        begin
            m[i] = (3'(i) < n);
        end
        return m;
    endfunction

endpackage

// ===== design/hbp_front.sv =====
// front end: accepts items, keeps the code table and its valid marks,
// looks up encode symbols and hands jobs to the queue; uses hbp_pkg
module hbp_front
    import hbp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // symbol, code_bits, code_len, zero pad
    input  logic [OP_W-1:0]    s_tuser,   // op
    input  logic [Q_LVL_W-1:0] q_level,
    output logic               q_push,
    output hbp_cmd_t           q_cmd
);

    localparam int ENT_W = LEN_W + CODE_W;

    logic [ENT_W-1:0]       mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] vld_reg;
    logic [ENT_W-1:0]       rd_reg;
    logic                   rd_vld_reg;
    logic                   p1_vld_reg;
    logic                   p1_flush_reg;

    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
    logic [LEN_W-1:0]  sat_len;
    logic              accept;
    logic              is_load;
    logic              is_enc;
    logic              is_flush;

    assign symbol    = s_tdata[SYM_W-1:0];
    assign code_bits = s_tdata[SYM_W+CODE_W-1:SYM_W];
    assign code_len  = s_tdata[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W];
    assign sat_len   = (code_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : code_len;

    // reserve a queue slot for the item sitting in the lookup stage
    assign s_tready = ((Q_LVL_W+1)'(q_level) + (Q_LVL_W+1)'(p1_vld_reg))
                      < (Q_LVL_W+1)'(Q_DEPTH);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        is_load  = 1'b0;
        is_enc   = 1'b0;
        is_flush = 1'b0;
        case (op_t'(s_tuser))
            OP_LOAD:   is_load  = 1'b1;
            OP_ENCODE: is_enc   = 1'b1;
            OP_FLUSH:  is_flush = 1'b1;
            default:   ;
        endcase
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (accept && is_load)
        begin
            mem[symbol] <= {sat_len, code_bits & code_mask(sat_len)};
        end
        if (accept && is_enc)
        begin
            rd_reg <= mem[symbol];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            p1_vld_reg   <= 1'b0;
            p1_flush_reg <= 1'b0;
        end
        else
        begin
            if (accept && is_load)
            begin
                vld_reg[symbol] <= 1'b1;
            end
            rd_vld_reg   <= accept && is_enc && vld_reg[symbol];
            p1_vld_reg   <= accept && (is_enc || is_flush);
            p1_flush_reg <= is_flush;
        end
    end

    // unknown symbols drop out here
    assign q_push     = p1_vld_reg && (p1_flush_reg || rd_vld_reg);
    assign q_cmd.flush = p1_flush_reg;
    assign q_cmd.len   = p1_flush_reg ? '0 : rd_reg[ENT_W-1:CODE_W];
    assign q_cmd.code  = p1_flush_reg ? '0 : rd_reg[CODE_W-1:0];

endmodule

// ===== design/hbp_fifo.sv =====
// short job queue between the front end and the bit packer
// uses hbp_pkg for the job type and depth
module hbp_fifo
    import hbp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hbp_cmd_t           push_cmd,
    input  logic               pop,
    output hbp_cmd_t           head,
    output logic               nonempty,
    output logic [Q_LVL_W-1:0] level
);

    hbp_cmd_t             slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_LVL_W-1:0]   lvl_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            lvl_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   lvl_reg <= lvl_reg + 1'b1;
                2'b01:   lvl_reg <= lvl_reg - 1'b1;
                default: lvl_reg <= lvl_reg;
            endcase
        end
    end

    assign head     = slot_reg[rd_ptr_reg];
    assign nonempty = (lvl_reg != '0);
    assign level    = lvl_reg;

endmodule

// ===== design/hbp_back.sv =====
// back end: bit accumulator that appends codes and emits bytes msb first,
// with the output register of the result stream; uses hbp_pkg
module hbp_back
    import hbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  hbp_cmd_t          cmd,
    input  logic              cmd_vld,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // packed_byte
    output logic              m_tlast    // last_of_run
);

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [TOT_W-1:0]  tot_reg, tot_next;
    logic              out_vld_reg, out_vld_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic              slot_free;
    logic              has_byte;
    logic              emit;
    logic [TOT_W-1:0]  rem;
    logic [TOT_W-1:0]  eff_tot;
    logic              pop_enc;
    logic              pop_flush;
    logic [PEND_W-1:0] pend;
    logic [ACC_W-1:0]  appended;
    logic [BYTE_W-1:0] emit_byte;
    logic [BYTE_W-1:0] flush_byte;

    assign slot_free = !out_vld_reg || m_tready;
    assign has_byte  = (tot_reg >= TOT_W'(BYTE_W));
    assign emit      = has_byte && slot_free;
    assign rem       = tot_reg - TOT_W'(BYTE_W);
    assign eff_tot   = emit ? rem : tot_reg;

    // an encode may enter in the same cycle as the last byte of the previous one
    assign pop_enc   = cmd_vld && !cmd.flush
                       && (!has_byte || (emit && rem < TOT_W'(BYTE_W)));
    assign pop_flush = cmd_vld && cmd.flush && !has_byte && slot_free;
    assign pop       = pop_enc || pop_flush;

    assign pend       = acc_reg[PEND_W-1:0] & pend_mask(eff_tot[2:0]);
    assign appended   = (ACC_W'(pend) << cmd.len) | ACC_W'(cmd.code);
    assign emit_byte  = BYTE_W'(acc_reg >> rem);
    assign flush_byte = BYTE_W'((2*BYTE_W)'(pend) << (4'd8 - {1'b0, eff_tot[2:0]}));

    always_comb
    begin
        acc_next      = acc_reg;
        tot_next      = tot_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        if (emit)
        begin
            tot_next      = rem;
            out_vld_next  = 1'b1;
            out_byte_next = emit_byte;
            out_last_next = (rem < TOT_W'(BYTE_W));
        end
        if (pop_enc)
        begin
            acc_next = appended;
            tot_next = eff_tot + TOT_W'(cmd.len);
        end
        if (pop_flush)
        begin
            acc_next      = '0;
            tot_next      = '0;
            out_vld_next  = 1'b1;
            out_byte_next = flush_byte;
            out_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            tot_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            tot_reg     <= tot_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/huffman_encode_bit_packer.sv =====
// path: lookup stage, queue, then the accumulator (encode only) and the output register
// throughput: one item per cycle while each code completes at most one byte and the receiver
// keeps up; a code that completes more bytes holds the packer until its extra bytes are out
// (one byte per cycle while m_tready is high); a flush never pops with an encode's last byte
// reset: table valid marks and pending bits cleared at once, no clearing pass; table
// contents are undefined until loaded
module huffman_encode_bit_packer
    import hbp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // symbol, code_bits, code_len, zero pad
    input  logic [OP_W-1:0]    s_tuser,   // op
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [BYTE_W-1:0]  m_tdata,   // packed_byte
    output logic               m_tlast    // last_of_run
);

    logic               q_push;
    hbp_cmd_t           q_cmd;
    logic               q_pop;
    hbp_cmd_t           q_head;
    logic               q_nonempty;
    logic [Q_LVL_W-1:0] q_level;

    hbp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_level  (q_level),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    hbp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .nonempty (q_nonempty),
        .level    (q_level)
    );

    hbp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (q_head),
        .cmd_vld  (q_nonempty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== test/huffman_encode_bit_packer_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for huffman_encode_bit_packer: table loads, encodes and flushes
// driven on the stream input and compared with a local bit packer model; needs hbp_pkg
module huffman_encode_bit_packer_tb;
    import hbp_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_ITEMS   = 375;
    localparam int QUIET_ITEMS  = 60;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 30;
    localparam int NUM_ROWS     = 25;
    localparam int PREDICT      = -1;

    typedef struct {
        logic [BYTE_W-1:0] pbyte;
        logic              last;
    } packed_out_t;

    // typed_n: bytes written into the row by hand, or PREDICT to take them from the model
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        int                typed_n;
        logic [BYTE_W-1:0] typed_byte;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;   // symbol, code_bits, code_len, zero pad
    logic [OP_W-1:0]    s_tuser = '0;   // op
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [BYTE_W-1:0]  m_tdata;        // packed_byte
    logic               m_tlast;        // last_of_run

    // model state
    logic [CODE_W-1:0] code_tab [TABLE_DEPTH];
    logic [LEN_W-1:0]  len_tab [TABLE_DEPTH];
    bit                valid_tab [TABLE_DEPTH];
    logic [PEND_W-1:0] pend_bits;
    int                pend_cnt;

    packed_out_t      exp_bytes [$];
    logic [SYM_W-1:0] loaded_syms [$];
    int               err_cnt = 0;
    int               cycle_cnt = 0;
    bit               idle_on = 1'b1;
    bit               hold_req = 1'b0;

    dir_row_t dir_rows [NUM_ROWS] = '{
        '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1, 8'h00},   // empty flush after reset
        '{OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  0, 8'h00},   // symbol never loaded
        '{OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, 0, 8'h00},
        '{OP_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd0,  0, 8'h00},   // zero-length code
        '{OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  0, 8'h00},
        '{OP_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'd63, 1, 8'h00},
        '{OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32, 0, 8'h00},   // longest code
        '{OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  PREDICT, 8'h00},
        '{OP_LOAD,   8'h01, 32'h0000_0005, 6'd3,  0, 8'h00},
        '{OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  PREDICT, 8'h00},
        '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  PREDICT, 8'h00},
        '{OP_LOAD,   8'h80, 32'hAAAA_AAAA, 6'd63, 0, 8'h00},   // length saturates
        '{OP_LOAD,   8'h02, 32'h0000_007F, 6'd7,  0, 8'h00},
        '{OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  PREDICT, 8'h00},
        '{OP_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  PREDICT, 8'h00},   // 7 + 32 bits pending
        '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  PREDICT, 8'h00},
        '{OP_LOAD,   8'h01, 32'h0000_0001, 6'd1,  0, 8'h00},   // overwrite an entry
        '{OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  PREDICT, 8'h00},
        '{OP_LOAD,   8'h7F, 32'h1234_5678, 6'd33, 0, 8'h00},
        '{OP_ENCODE, 8'h7F, 32'h0000_0000, 6'd0,  PREDICT, 8'h00},
        '{OP_LOAD,   8'h55, 32'hFFFF_FFF3, 6'd5,  0, 8'h00},   // bits above length ignored
        '{OP_ENCODE, 8'h55, 32'h0000_0000, 6'd0,  PREDICT, 8'h00},
        '{OP_ENCODE, 8'hFE, 32'hFFFF_FFFF, 6'd63, 0, 8'h00},   // unknown with bits pending
        '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  PREDICT, 8'h00},
        '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1, 8'h00}
    };

    huffman_encode_bit_packer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // update the packer model for one accepted item; keep queues the bytes it yields
    function automatic void predict_packer(input logic [OP_W-1:0] op,
                                           input logic [SYM_W-1:0] sym,
                                           input logic [CODE_W-1:0] code,
                                           input logic [LEN_W-1:0] len,
                                           input bit keep);
        logic [63:0] acc;
        int          n;
        int          total;
        packed_out_t r;
        case (op)
            OP_LOAD:
            begin
                n = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len);
                code_tab[sym]  = code;
                len_tab[sym]   = LEN_W'(n);
                valid_tab[sym] = 1'b1;
            end
            OP_ENCODE:
            begin
                if (valid_tab[sym])
                begin
                    n     = len_tab[sym];
                    acc   = (64'(pend_bits) << n) | (64'(code_tab[sym]) & ((64'd1 << n) - 64'd1));
                    total = pend_cnt + n;
                    while (total >= BYTE_W)
                    begin
                        total   -= BYTE_W;
                        r.pbyte = BYTE_W'(acc >> total);
                        r.last  = (total < BYTE_W);
                        if (keep)
                            exp_bytes.push_back(r);
                    end
                    pend_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
                    pend_cnt  = total;
                end
            end
            OP_FLUSH:
            begin
                r.pbyte = BYTE_W'(16'(pend_bits) << (BYTE_W - pend_cnt));
                r.last  = 1'b1;
                if (keep)
                    exp_bytes.push_back(r);
                pend_bits = '0;
                pend_cnt  = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        if (err_cnt < 40)
            $display("mismatch at %0t: %s got 0x%02h want 0x%02h", $realtime, what, got, want);
        err_cnt++;
    endtask

    // caller sits at a falling edge; returns at the falling edge after the transaction
    task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                             input int typed_n, input logic [BYTE_W-1:0] typed_byte);
        packed_out_t r;
        if (idle_on && $urandom_range(0, 6) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= TDATA_W'({len, code, sym});
        do @(posedge clk); while (!s_tready);
        predict_packer(op, sym, code, len, typed_n == PREDICT);
        if (typed_n > 0)
        begin
            r.pbyte = typed_byte;
            r.last  = 1'b1;
            exp_bytes.push_back(r);
        end
        @(negedge clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return LEN_W'($urandom_range(1, 8));
        else if (r < 88)
            return LEN_W'($urandom_range(9, 20));
        else if (r < 95)
            return LEN_W'($urandom_range(21, 32));
        else if (r < 97)
            return '0;
        return LEN_W'($urandom_range(33, 63));
    endfunction

    // receiver: random stalls, plus one long hold-off to back the block up
    initial
    begin
        int hold_cnt;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES)
                begin
                    @(negedge clk);
                    hold_cnt++;
                end
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        packed_out_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (exp_bytes.size() == 0)
                report_mismatch("unexpected byte", m_tdata, 8'h00);
            else
            begin
                e = exp_bytes.pop_front();
                if (m_tdata !== e.pbyte)
                    report_mismatch("packed_byte", m_tdata, e.pbyte);
                if (m_tlast !== e.last)
                    report_mismatch("last_of_run", BYTE_W'(m_tlast), BYTE_W'(e.last));
            end
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int               done;
        int               r;
        logic [OP_W-1:0]  op;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
        bit               ignored;
        for (int i = 0; i < TABLE_DEPTH; i++)
            valid_tab[i] = 1'b0;
        pend_bits = '0;
        pend_cnt  = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].sym, dir_rows[i].code, dir_rows[i].len,
                      dir_rows[i].typed_n, dir_rows[i].typed_byte);

        // build up a table first so most encodes hit loaded symbols
        repeat (20)
        begin
            sym = SYM_W'($urandom_range(0, TABLE_DEPTH - 1));
            if (!valid_tab[sym])
                loaded_syms.push_back(sym);
            send_item(OP_LOAD, sym, $urandom(), pick_len(), PREDICT, 8'h00);
        end

        done = 0;
        while (done < RAND_ITEMS)
        begin
            r   = $urandom_range(0, 99);
            sym = SYM_W'($urandom_range(0, TABLE_DEPTH - 1));
            len = LEN_W'($urandom_range(0, 63));
            if (r < 10)
            begin
                op  = OP_LOAD;
                len = pick_len();
                if (!valid_tab[sym])
                    loaded_syms.push_back(sym);
            end
            else if (r < 82)
            begin
                op = OP_ENCODE;
                if ($urandom_range(0, 9) != 0)
                    sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            end
            else if (r < 96)
                op = OP_FLUSH;
            else
                op = OP_UNUSED;
            ignored = (op == OP_UNUSED) || (op == OP_ENCODE && !valid_tab[sym]);
            if (done >= RAND_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            send_item(op, sym, $urandom(), len, PREDICT, 8'h00);
            if (!ignored)
            begin
                done++;
                if (done == HOLD_AT)
                    hold_req = 1'b1;
            end
        end
        s_tvalid <= 1'b0;

        while (exp_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/hbp_pkg.sv
design/hbp_front.sv
design/hbp_fifo.sv
design/hbp_back.sv
design/huffman_encode_bit_packer.sv
test/huffman_encode_bit_packer_tb.sv
